FILE: hdl/z80af_pkg.sv
// z80af_pkg: operation codes and the ALU result bundle for the Z80 ALU core.
// No dependencies; imported by z80af_alu and z80_alu_flags_core.
package z80af_pkg;

   typedef enum logic [3:0] {
      ACT_ADD  = 4'd0,
      ACT_ADC  = 4'd1,
      ACT_SUB  = 4'd2,
      ACT_SBC  = 4'd3,
      ACT_CP   = 4'd4,
      ACT_AND  = 4'd5,
      ACT_OR   = 4'd6,
      ACT_XOR  = 4'd7,
      ACT_INC  = 4'd8,
      ACT_DEC  = 4'd9,
      ACT_RLCA = 4'd10,
      ACT_RRCA = 4'd11,
      ACT_RLA  = 4'd12,
      ACT_RRA  = 4'd13,
      ACT_DAA  = 4'd14
   } action_type;

   // flag byte bit positions
   localparam int unsigned FLAG_C  = 0;
   localparam int unsigned FLAG_N  = 1;
   localparam int unsigned FLAG_PV = 2;
   localparam int unsigned FLAG_H  = 4;
   localparam int unsigned FLAG_Z  = 6;
   localparam int unsigned FLAG_S  = 7;

   typedef struct packed {
      logic [7:0] result;
      logic [7:0] flags;
      logic       write;
   } alu_result_type;

endpackage

FILE: hdl/z80af_alu.sv
// z80af_alu: combinational 8-bit Z80 ALU with flag generation.
// Depends on z80af_pkg (action codes, flag positions, result bundle).
module z80af_alu
   import z80af_pkg::*;
(
   input  action_type     action,
   input  logic [7:0]     acc,
   input  logic [7:0]     operand,
   input  logic [7:0]     flags_in,
   output alu_result_type alu_out
);

   // S Z H PV N C assembled around the undocumented bits 5 and 3 of flags_in
   function automatic logic [7:0] pack_flags(input logic [7:0] r, input logic h,
                                             input logic pv, input logic n,
                                             input logic c, input logic [7:0] f);
      return {r[7], (r == 8'h00), f[5], h, f[3], pv, n, c};
   endfunction

   logic       cin;
   logic       add_c;
   logic       sub_c;
   logic [8:0] add_sum;
   logic [4:0] add_nib;
   logic [8:0] sub_diff;
   logic [4:0] sub_nib;
   logic [7:0] logic_r;
   logic [7:0] inc_r;
   logic [7:0] dec_r;
   logic [7:0] daa_t;
   logic       daa_c;
   logic [7:0] daa_r;
   logic [4:0] daa_nib;

   assign cin   = flags_in[FLAG_C];
   assign add_c = (action == ACT_ADC) & cin;
   assign sub_c = (action == ACT_SBC) & cin;

   assign add_sum  = {1'b0, acc} + {1'b0, operand} + {8'd0, add_c};
   assign add_nib  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, add_c};
   assign sub_diff = {1'b0, acc} - {1'b0, operand} - {8'd0, sub_c};
   assign sub_nib  = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, sub_c};

   assign inc_r = operand + 8'd1;
   assign dec_r = operand - 8'd1;

   // addition-only decimal adjust
   assign daa_t[3:0] = ((acc[3:0] > 4'd9) || flags_in[FLAG_H]) ? 4'h6 : 4'h0;
   assign daa_c      = (acc > 8'h99) || cin;
   assign daa_t[7:4] = daa_c ? 4'h6 : 4'h0;
   assign daa_r      = acc + daa_t;
   assign daa_nib    = {1'b0, acc[3:0]} + {1'b0, daa_t[3:0]};

   always_comb begin
      unique case (action)
         ACT_AND: logic_r = acc & operand;
         ACT_OR:  logic_r = acc | operand;
         default: logic_r = acc ^ operand;
      endcase
   end

   always_comb begin
      alu_out.result = acc;
      alu_out.flags  = flags_in;
      alu_out.write  = 1'b1;
      unique case (action)
         ACT_ADD, ACT_ADC: begin
            alu_out.result = add_sum[7:0];
            alu_out.flags  = pack_flags(add_sum[7:0], add_nib[4],
                                 (acc[7] ^ add_sum[7]) & (operand[7] ^ add_sum[7]),
                                 1'b0, add_sum[8], flags_in);
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            if (action != ACT_CP) begin
               alu_out.result = sub_diff[7:0];
            end else begin
               alu_out.write = 1'b0;
            end
            alu_out.flags = pack_flags(sub_diff[7:0], sub_nib[4],
                                 (acc[7] ^ operand[7]) & (acc[7] ^ sub_diff[7]),
                                 1'b1, sub_diff[8], flags_in);
         end
         ACT_AND, ACT_OR, ACT_XOR: begin
            alu_out.result = logic_r;
            alu_out.flags  = pack_flags(logic_r, action == ACT_AND, ~^logic_r,
                                        1'b0, 1'b0, flags_in);
         end
         ACT_INC: begin
            alu_out.result = inc_r;
            alu_out.flags  = pack_flags(inc_r, operand[3:0] == 4'hF,
                                        operand == 8'h7F, 1'b0, cin, flags_in);
         end
         ACT_DEC: begin
            alu_out.result = dec_r;
            alu_out.flags  = pack_flags(dec_r, operand[3:0] == 4'h0,
                                        operand == 8'h80, 1'b1, cin, flags_in);
         end
         ACT_RLCA: begin
            alu_out.result = {acc[6:0], acc[7]};
            alu_out.flags  = {flags_in[7:5], 1'b0, flags_in[3:2], 1'b0, acc[7]};
         end
         ACT_RRCA: begin
            alu_out.result = {acc[0], acc[7:1]};
            alu_out.flags  = {flags_in[7:5], 1'b0, flags_in[3:2], 1'b0, acc[0]};
         end
         ACT_RLA: begin
            alu_out.result = {acc[6:0], cin};
            alu_out.flags  = {flags_in[7:5], 1'b0, flags_in[3:2], 1'b0, acc[7]};
         end
         ACT_RRA: begin
            alu_out.result = {cin, acc[7:1]};
            alu_out.flags  = {flags_in[7:5], 1'b0, flags_in[3:2], 1'b0, acc[0]};
         end
         ACT_DAA: begin
            alu_out.result = daa_r;
            alu_out.flags  = pack_flags(daa_r, daa_nib[4], ~^daa_r,
                                        flags_in[FLAG_N], daa_c, flags_in);
         end
         default: begin
            // unused code: pass acc and flags, no writeback
            alu_out.result = acc;
            alu_out.flags  = flags_in;
            alu_out.write  = 1'b0;
         end
      endcase
   end

endmodule

FILE: hdl/z80_alu_flags_core.sv
// z80_alu_flags_core: registered Z80 8-bit ALU with flag generation.
// Depends on z80af_pkg and z80af_alu.
//
// One word in, one word out. A request word carries an operation code, the
// accumulator, an operand (the target register for INC/DEC) and the current
// flag byte; the response word carries the result byte, the new flag byte
// (bits 5 and 3 copied from the input) and a writeback enable that is low for
// CP and for the unused code 15. An accepted request is loaded into the input
// register, the ALU and flag network work on it, and the result is loaded
// into the output register as soon as that register is free to take it.
// Throughput is one word per clock; both registers advance together
// so a new request is taken every cycle while the response side keeps up.
// When rsp_stall holds a finished word, the output register keeps it and the
// input register can still fill once more; req_stall rises only when both
// registers are full and the response side is stalled. No configuration, no
// state beyond the two pipeline registers.
module z80_alu_flags_core
   import z80af_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_action,
   input  logic [7:0] req_acc,
   input  logic [7:0] req_operand,
   input  logic [7:0] req_flags_in,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result,
   output logic [7:0] rsp_flags_out,
   output logic       rsp_write_result
);

   // input register
   logic           in_valid_ff, in_valid_in;
   action_type     in_action_ff;
   logic [7:0]     in_acc_ff;
   logic [7:0]     in_operand_ff;
   logic [7:0]     in_flags_ff;

   // output register
   logic           out_valid_ff, out_valid_in;
   alu_result_type out_ff;

   alu_result_type alu_res;
   logic           req_take;
   logic           out_free;
   logic           out_load;

   // output slot is free when empty or its word leaves this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign out_load  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff  <= action_type'(req_action);
         in_acc_ff     <= req_acc;
         in_operand_ff <= req_operand;
         in_flags_ff   <= req_flags_in;
      end
      if (out_load) begin
         out_ff <= alu_res;
      end
   end

   z80af_alu u_alu (
      .action   (in_action_ff),
      .acc      (in_acc_ff),
      .operand  (in_operand_ff),
      .flags_in (in_flags_ff),
      .alu_out  (alu_res)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_result       = out_ff.result;
   assign rsp_flags_out    = out_ff.flags;
   assign rsp_write_result = out_ff.write;

`ifndef SYNTHESIS
   // a word in the input register moves to the output when the slot is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> out_valid_ff)
      else $error("input word not moved to output register");

   // a stalled response word is never dropped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff)
      else $error("stalled response word lost");

   // back-pressure only when both registers are occupied and output is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   // rotates keep S, Z and PV
   a_rot_keep: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (in_action_ff == ACT_RLCA || in_action_ff == ACT_RRCA ||
                      in_action_ff == ACT_RLA || in_action_ff == ACT_RRA)
      |-> (alu_res.flags[FLAG_S] == in_flags_ff[FLAG_S] &&
           alu_res.flags[FLAG_Z] == in_flags_ff[FLAG_Z] &&
           alu_res.flags[FLAG_PV] == in_flags_ff[FLAG_PV]))
      else $error("rotate changed S, Z or PV");
`endif

endmodule
